@@ src/water_ripple_field_engine_macros.svh @@
// Assertion macros used by the file that checks this block.
`ifndef WATER_RIPPLE_FIELD_ENGINE_MACROS_SVH
`define WATER_RIPPLE_FIELD_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wrf_pkg.sv @@
package wrf_pkg;

  // Default field dimensions.
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // Word layouts.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  // Configuration reset values.
  localparam logic [6:0] RST_WIDTH  = 7'd64;
  localparam logic [6:0] RST_HEIGHT = 7'd64;
  localparam logic [4:0] RST_DAMP   = 5'd5;

  // Operation codes.
  typedef enum logic [2:0] {
    F_WRITE  = 3'd0,
    F_ADD    = 3'd1,
    F_READ   = 3'd2,
    F_STEP   = 3'd3,
    F_SMOOTH = 3'd4,
    F_CLEAR  = 3'd5
  } wrf_func_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DAMP   = 2'd2
  } wrf_cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_run;
    logic walk_run;
    logic cell_wr;
    logic load_out;
  } wrf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clr_last;
    logic       walk_last;
    logic       out_free;
  } wrf_sts_t;

endpackage

@@ src/wrf_ram.sv @@
module wrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ src/wrf_ctrl.sv @@
module wrf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [2:0]       func_in,
  input  wrf_pkg::wrf_sts_t sts,
  output wrf_pkg::wrf_cmd_t cmd
);
  import wrf_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CELL0 = 6'b000100,
    S_CELL1 = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   reply_r, reply_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    reply_nxt    = reply_r;
    cmd          = '0;
    cmd.accept   = in_tvalid && (state_r == S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_last) begin
          state_nxt = reply_r ? S_DONE : S_IDLE;
          reply_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          case (func_in)
            F_WRITE, F_ADD, F_READ: state_nxt = S_CELL0;
            F_STEP, F_SMOOTH:       state_nxt = S_WALK;
            F_CLEAR: begin
              state_nxt = S_CLEAR;
              reply_nxt = 1'b1;
            end
            default:                state_nxt = S_DONE;
          endcase
        end
      end
      S_CELL0: state_nxt = S_CELL1;
      S_CELL1: begin
        cmd.cell_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_WALK: begin
        cmd.walk_run = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers; reset starts with a clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

endmodule

@@ src/wrf_dp.sv @@
module wrf_dp #(
  parameter int MAX_COLS = wrf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = wrf_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [wrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [wrf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [wrf_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wrf_pkg::wrf_cmd_t           cmd,
  output wrf_pkg::wrf_sts_t           sts
);
  import wrf_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CMPW  = (CNW > RNW) ? ((CNW > 7) ? CNW : 7) : ((RNW > 7) ? RNW : 7);
  localparam logic [2:0] PH_N  = 3'd5;
  localparam logic [2:0] PH_WR = 3'd6;
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_COLS);

  // Configuration registers.
  logic [6:0] width_r, height_r;
  logic [4:0] damp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      damp_r   <= RST_DAMP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        CFG_DAMP:   damp_r   <= cfg_wdata[4:0];
        default:    ;
      endcase
    end
  end

  // Effective size, saturated to the supported range.
  logic [CNW-1:0] w_eff, w_lim;
  logic [RNW-1:0] h_eff, h_lim;

  always_comb begin
    if (CMPW'(width_r) < CMPW'(3)) begin
      w_eff = CNW'(3);
    end else if (CMPW'(width_r) > CMPW'(MAX_COLS)) begin
      w_eff = CNW'(MAX_COLS);
    end else begin
      w_eff = CNW'(width_r);
    end
    if (CMPW'(height_r) < CMPW'(3)) begin
      h_eff = RNW'(3);
    end else if (CMPW'(height_r) > CMPW'(MAX_ROWS)) begin
      h_eff = RNW'(MAX_ROWS);
    end else begin
      h_eff = RNW'(height_r);
    end
  end

  assign w_lim = w_eff - CNW'(2);
  assign h_lim = h_eff - RNW'(2);

  // Latched input word.
  logic [2:0]         func_r;
  logic [5:0]         col_r, row_r;
  logic               which_r;
  logic signed [31:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_tdata[2:0];
      col_r   <= in_tdata[8:3];
      row_r   <= in_tdata[14:9];
      val_r   <= in_tdata[46:15];
      which_r <= in_tuser;
    end
  end

  // Single cell access.
  logic [AW-1:0] cell_addr;
  logic          cell_in, cell_wen;

  assign cell_addr = AW'(32'(row_r) * MAX_COLS + 32'(col_r));
  assign cell_in   = (CMPW'(col_r) < CMPW'(w_eff)) && (CMPW'(row_r) < CMPW'(h_eff));
  assign cell_wen  = cell_in && ((func_r == F_WRITE) || (func_r == F_ADD));

  // Interior walk counters and accumulators.
  logic [CNW-1:0]     x_r;
  logic [RNW-1:0]     y_r;
  logic [AW-1:0]      c_r;
  logic [2:0]         ph_r;
  logic signed [31:0] acc_r, nc_r, n_r;
  logic [AW-1:0]      clr_cnt_r;
  logic               page_r;
  logic [31:0]        res_r;

  logic [AW-1:0]      nb_a, nb_b;
  logic [31:0]        rda [2];
  logic [31:0]        rdb [2];
  logic signed [31:0] old_a, old_b, new_a, wr_val;
  logic [31:0]        cell_rdata;

  // Neighbor addresses, two per phase.
  always_comb begin
    case (ph_r)
      3'd0: begin
        nb_a = c_r - ROW_STEP - AW'(1);
        nb_b = c_r - ROW_STEP;
      end
      3'd1: begin
        nb_a = c_r - ROW_STEP + AW'(1);
        nb_b = c_r - AW'(1);
      end
      3'd2: begin
        nb_a = c_r + AW'(1);
        nb_b = c_r + ROW_STEP - AW'(1);
      end
      default: begin
        nb_a = c_r + ROW_STEP;
        nb_b = c_r + ROW_STEP + AW'(1);
      end
    endcase
  end

  // With page zero the first store is new and the second is old.
  assign old_a      = page_r ? rda[0] : rda[1];
  assign old_b      = page_r ? rdb[0] : rdb[1];
  assign new_a      = page_r ? rda[1] : rda[0];
  assign cell_rdata = which_r ? rda[1] : rda[0];

  assign wr_val = (func_r == F_STEP) ? (n_r - (n_r >>> damp_r)) : (n_r >>> 1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r  <= CNW'(1);
      y_r  <= RNW'(1);
      c_r  <= ROW_STEP + AW'(1);
      ph_r <= 3'd0;
    end else if (cmd.walk_run) begin
      unique case (ph_r)
        3'd1: begin
          acc_r <= old_a + old_b;
          nc_r  <= new_a;
        end
        3'd2, 3'd3, 3'd4: acc_r <= acc_r + old_a + old_b;
        PH_N: begin
          if (func_r == F_STEP) begin
            n_r <= (acc_r >>> 2) - nc_r;
          end else begin
            n_r <= (acc_r >>> 3) + nc_r;
          end
        end
        default: ;
      endcase
      if (ph_r == PH_WR) begin
        ph_r <= 3'd0;
        if (x_r == w_lim) begin
          x_r <= CNW'(1);
          y_r <= y_r + RNW'(1);
          c_r <= c_r + ROW_STEP - AW'(w_eff) + AW'(3);
        end else begin
          x_r <= x_r + CNW'(1);
          c_r <= c_r + AW'(1);
        end
      end else begin
        ph_r <= ph_r + 3'd1;
      end
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.accept) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_run) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Page bit flips when a ripple step finishes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= 1'b0;
    end else if (cmd.walk_run && sts.walk_last && (func_r == F_STEP)) begin
      page_r <= ~page_r;
    end
  end

  // Read result.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_r <= '0;
    end else if (cmd.cell_wr && cell_in && (func_r == F_READ)) begin
      res_r <= cell_rdata;
    end
  end

  // The two height stores.
  for (genvar k = 0; k < 2; k++) begin : g_field
    logic          we;
    logic [AW-1:0] wa, ra;
    logic [31:0]   wd;
    logic          is_new;

    assign is_new = (page_r == 1'(k));

    always_comb begin
      we = 1'b0;
      wa = clr_cnt_r;
      wd = '0;
      if (cmd.clr_run) begin
        we = 1'b1;
      end else if (cmd.walk_run && (ph_r == PH_WR) && is_new) begin
        we = 1'b1;
        wa = c_r;
        wd = wr_val;
      end else if (cmd.cell_wr && cell_wen && (which_r == 1'(k))) begin
        we = 1'b1;
        wa = cell_addr;
        wd = (func_r == F_ADD) ? (cell_rdata + val_r) : val_r;
      end
      ra = cmd.walk_run ? (is_new ? c_r : nb_a) : cell_addr;
    end

    wrf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clk     (clk),
      .we      (we),
      .waddr   (wa),
      .wdata   (wd),
      .raddr_a (ra),
      .raddr_b (nb_b),
      .rdata_a (rda[k]),
      .rdata_b (rdb[k])
    );
  end

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {7'd0, page_r, res_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.walk_last = (ph_r == PH_WR) && (x_r == w_lim) && (y_r == h_lim);
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

@@ src/water_ripple_field_engine.sv @@
// Two ping-pong height fields of MAX_ROWS x MAX_COLS 32-bit cells plus a page bit.
// The input channel takes one operation word per item; every item yields
// exactly one result word on the output channel (read height, page bit).
// The user is to write configuration through cfg_we/cfg_index/cfg_wdata only
// while idle; the block itself does not enforce this. Cell write, add and read
// pass through states CELL0, CELL1 and DONE before the result is loaded.
// A step or smooth walks each interior cell in turn; the two shared read ports
// of the old field fetch the eight neighbors of each cell.
// A clear zeroes both fields, one cell a cycle.
// Unused operation codes go straight to DONE and return a zero height.
// One item is worked on at a time; in_tready is high only while idle.
// After reset both fields are swept to zero with in_tready low; configuration
// writes are taken as ever. The result sits in an output register: the next
// item is accepted while it waits, and if the receiver stalls the block holds
// its next result until that register empties.
module water_ripple_field_engine #(
  parameter int MAX_COLS = wrf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = wrf_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // func[2:0], col[8:3], row[14:9], cell_value[46:15], zero[47]
  input  logic [wrf_pkg::IN_DATA_W-1:0]  in_tdata,
  // which_field[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_height[31:0], current_page[32], zero[39:33]
  output logic [wrf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import wrf_pkg::*;

`include "water_ripple_field_engine_macros.svh"

  wrf_cmd_t cmd;
  wrf_sts_t sts;

  wrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .func_in   (in_tdata[2:0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  wrf_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Checks on controller and datapath cooperation.
  `WRF_ASSERT_NEXT(a_one_item, (in_tvalid && in_tready), (!in_tready), "item accepted while busy")
  `WRF_ASSERT_SAME(a_cmd_excl, 1'b1, ($onehot0({cmd.clr_run, cmd.walk_run, cmd.cell_wr, cmd.load_out})), "commands overlap")
  `WRF_ASSERT_NEXT(a_load_shows, cmd.load_out, out_tvalid, "loaded result not presented")

endmodule
